@@ design/clrng_pkg.sv @@
// Shared types and constants for the combined LCG / xorshift / MWC generator.
// No dependencies; every other file in this folder refers to it by scoped names.
`timescale 1ns / 1ps

package clrng_pkg;

    // Word width of the generator state, the bound and the result.
    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;

    // Generator constants.
    localparam logic [WORD_W-1:0] XS_INIT = 64'd4101842887655102017;
    localparam logic [WORD_W-1:0] LCG_MUL = 64'd2862933555777941757;
    localparam logic [WORD_W-1:0] LCG_ADD = 64'd7046029254386353087;
    localparam logic [HALF_W-1:0] MWC_MUL = 32'd4294957665;

    // Byte address of the seed register on the configuration port.
    localparam int               ADDR_W    = 3;
    localparam logic [ADDR_W-1:0] ADDR_SEED = 3'd0;

    // Commands from the request sequencer to the generator.
    typedef struct packed {
        logic draw;
        logic reseed;
    } gen_cmd_t;

endpackage

@@ design/clrng_div.sv @@
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on clrng_pkg for the word width.
`timescale 1ns / 1ps

module clrng_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [clrng_pkg::WORD_W-1:0]   dividend,
    input  logic [clrng_pkg::WORD_W-1:0]   divisor,
    output logic                           idle,
    output logic [clrng_pkg::WORD_W-1:0]   rem
);

    localparam int CNT_W = $clog2(clrng_pkg::WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(clrng_pkg::WORD_W - 1);

    logic                         busy_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [clrng_pkg::WORD_W-1:0] rem_reg;
    logic [clrng_pkg::WORD_W-1:0] dvd_reg;
    logic [clrng_pkg::WORD_W-1:0] dvs_reg;

    logic [clrng_pkg::WORD_W:0]   trial;
    logic [clrng_pkg::WORD_W:0]   diff;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, dvd_reg[clrng_pkg::WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // Control: busy while the dividend bits are shifted through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: partial remainder and dividend shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[clrng_pkg::WORD_W-2:0], 1'b0};
            if (!diff[clrng_pkg::WORD_W])
            begin
                rem_reg <= diff[clrng_pkg::WORD_W-1:0];
            end
            else
            begin
                rem_reg <= trial[clrng_pkg::WORD_W-1:0];
            end
        end
    end

    assign idle = !busy_reg;
    assign rem  = rem_reg;

endmodule

@@ design/clrng_gen.sv @@
// Generator state (LCG, xorshift and MWC words) stepped through one shared
// 32x32 multiplier under a small sequencer, including the reseed warm-up.
// Depends on clrng_pkg for constants and the command struct.
`timescale 1ns / 1ps

module clrng_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  clrng_pkg::gen_cmd_t            cmd,
    input  logic [clrng_pkg::WORD_W-1:0]   seed,
    output logic                           idle,
    output logic [clrng_pkg::WORD_W-1:0]   value
);

    localparam int W = clrng_pkg::WORD_W;
    localparam int H = clrng_pkg::HALF_W;

    // Sequencer codes.
    localparam logic [2:0] G_IDLE = 3'd0;
    localparam logic [2:0] G_LOAD = 3'd1;
    localparam logic [2:0] G_M0   = 3'd2;
    localparam logic [2:0] G_M1   = 3'd3;
    localparam logic [2:0] G_M2   = 3'd4;
    localparam logic [2:0] G_M3   = 3'd5;
    localparam logic [2:0] G_M4   = 3'd6;
    localparam logic [2:0] G_MIX  = 3'd7;

    logic [2:0]   state_reg;
    logic         reseeding_reg;
    logic [1:0]   warm_cnt_reg;

    logic [W-1:0] lcg_reg;
    logic [W-1:0] xs_reg;
    logic [W-1:0] mwc_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] prod_reg;
    logic [W-1:0] value_reg;

    logic [H-1:0] mul_a;
    logic [H-1:0] mul_b;
    logic [W-1:0] prod_next;
    logic [W-1:0] xs_t1;
    logic [W-1:0] xs_t2;
    logic [W-1:0] xs_next;
    logic [W-1:0] mix_t1;
    logic [W-1:0] mix_t2;
    logic [W-1:0] mix_t3;
    logic [W-1:0] draw_next;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            G_M0:
            begin
                mul_a = lcg_reg[H-1:0];
                mul_b = clrng_pkg::LCG_MUL[H-1:0];
            end
            G_M1:
            begin
                mul_a = lcg_reg[H-1:0];
                mul_b = clrng_pkg::LCG_MUL[W-1:H];
            end
            G_M2:
            begin
                mul_a = lcg_reg[W-1:H];
                mul_b = clrng_pkg::LCG_MUL[H-1:0];
            end
            G_M3:
            begin
                mul_a = mwc_reg[H-1:0];
                mul_b = clrng_pkg::MWC_MUL;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};

    // Xorshift step with shifts 17, 31 and 8.
    assign xs_t1   = xs_reg ^ (xs_reg >> 17);
    assign xs_t2   = xs_t1 ^ (xs_t1 << 31);
    assign xs_next = xs_t2 ^ (xs_t2 >> 8);

    // Output mix of the three freshly stepped words.
    assign mix_t1    = lcg_reg ^ (lcg_reg << 21);
    assign mix_t2    = mix_t1 ^ (mix_t1 >> 35);
    assign mix_t3    = mix_t2 ^ (mix_t2 << 4);
    assign draw_next = (mix_t3 + xs_reg) ^ mwc_reg;

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= G_IDLE;
            reseeding_reg <= 1'b0;
            warm_cnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                G_IDLE:
                begin
                    if (cmd.reseed)
                    begin
                        state_reg <= G_LOAD;
                    end
                    else if (cmd.draw)
                    begin
                        state_reg <= G_M0;
                    end
                end
                G_LOAD:
                begin
                    reseeding_reg <= 1'b1;
                    warm_cnt_reg  <= '0;
                    state_reg     <= G_M0;
                end
                G_M0: state_reg <= G_M1;
                G_M1: state_reg <= G_M2;
                G_M2: state_reg <= G_M3;
                G_M3: state_reg <= G_M4;
                G_M4: state_reg <= G_MIX;
                G_MIX:
                begin
                    if (reseeding_reg && warm_cnt_reg != 2'd2)
                    begin
                        warm_cnt_reg <= warm_cnt_reg + 1'b1;
                        state_reg    <= G_M0;
                    end
                    else
                    begin
                        reseeding_reg <= 1'b0;
                        state_reg     <= G_IDLE;
                    end
                end
                default: state_reg <= G_IDLE;
            endcase
        end
    end

    // Generator words and product register.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            G_LOAD:
            begin
                xs_reg  <= clrng_pkg::XS_INIT;
                mwc_reg <= {{(W-1){1'b0}}, 1'b1};
                lcg_reg <= seed ^ clrng_pkg::XS_INIT;
            end
            G_M0:
            begin
                xs_reg <= xs_next;
            end
            G_M1:
            begin
                acc_reg <= prod_reg + clrng_pkg::LCG_ADD;
            end
            G_M2:
            begin
                acc_reg <= acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
            end
            G_M3:
            begin
                lcg_reg <= acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
            end
            G_M4:
            begin
                mwc_reg <= prod_reg + {{H{1'b0}}, mwc_reg[W-1:H]};
            end
            G_MIX:
            begin
                value_reg <= draw_next;
                // Warm-up copy-over between the reseed draws.
                if (reseeding_reg && warm_cnt_reg == 2'd0)
                begin
                    xs_reg <= lcg_reg;
                end
                else if (reseeding_reg && warm_cnt_reg == 2'd1)
                begin
                    mwc_reg <= xs_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign idle  = (state_reg == G_IDLE);
    assign value = value_reg;

endmodule

@@ design/combined_lcg_xorshift_mwc_rng_core.sv @@
// A zero or power-of-two bound gives a masked draw; any other bound runs a classify step,
// the rejection threshold on the remainder unit, a generator draw that is repeated for each
// rejected draw, and the final remainder. One request at a time: the next transfer is not
// taken before the result loads, as the shared 32x32 multiplier and the bit-serial
// remainder unit serve a single request. After reset and after each seed write the block
// reseeds and holds in_stall high meanwhile.
`timescale 1ns / 1ps

module combined_lcg_xorshift_mwc_rng_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [clrng_pkg::WORD_W-1:0]   range_bound,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [clrng_pkg::WORD_W-1:0]   random_value,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [clrng_pkg::ADDR_W-1:0]   paddr,
    input  logic [clrng_pkg::WORD_W-1:0]   pwdata,
    output logic [clrng_pkg::WORD_W-1:0]   prdata,
    output logic                           pready
);

    localparam int W = clrng_pkg::WORD_W;

    // Request sequencer codes.
    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_CLASS = 3'd1;
    localparam logic [2:0] T_THR   = 3'd2;
    localparam logic [2:0] T_PDRAW = 3'd3;
    localparam logic [2:0] T_GDRAW = 3'd4;
    localparam logic [2:0] T_MOD   = 3'd5;

    logic [2:0]          state_reg;
    logic                reseed_pend_reg;
    logic                out_valid_reg;
    logic [W-1:0]        seed_reg;
    logic [W-1:0]        bound_reg;
    logic [W-1:0]        thr_reg;
    logic [W-1:0]        result_reg;

    logic                cfg_wr;
    logic                in_xfer;
    logic                out_free;
    logic                out_load;
    logic [W-1:0]        out_next;
    logic                bound_pow2;
    logic [W-1:0]        bound_mask;

    clrng_pkg::gen_cmd_t gen_cmd;
    logic                gen_idle;
    logic [W-1:0]        gen_value;

    logic                div_start;
    logic [W-1:0]        div_dividend;
    logic                div_idle;
    logic [W-1:0]        div_rem;

    // Configuration port: single seed register, zero wait states.
    assign cfg_wr = psel && penable && pwrite && (paddr == clrng_pkg::ADDR_SEED);
    assign pready = 1'b1;
    assign prdata = (paddr == clrng_pkg::ADDR_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= '0;
            reseed_pend_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            seed_reg        <= pwdata;
            reseed_pend_reg <= 1'b1;
        end
        else if (gen_cmd.reseed)
        begin
            reseed_pend_reg <= 1'b0;
        end
    end

    // Handshake.
    assign in_stall  = (state_reg != T_IDLE) || reseed_pend_reg || !gen_idle;
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign random_value = result_reg;

    // Bound classification: zero and powers of two are masked.
    assign bound_mask = bound_reg - 1'b1;
    assign bound_pow2 = ((bound_reg & bound_mask) == '0);

    // Result loads when the last step is done and the output register is free.
    always_comb
    begin
        out_load = 1'b0;
        out_next = div_rem;
        if (state_reg == T_PDRAW && gen_idle && out_free)
        begin
            out_load = 1'b1;
            out_next = gen_value & bound_mask;
        end
        else if (state_reg == T_MOD && div_idle && out_free)
        begin
            out_load = 1'b1;
            out_next = div_rem;
        end
    end

    // Commands to the generator and the remainder unit.
    always_comb
    begin
        gen_cmd.reseed = reseed_pend_reg && gen_idle && (state_reg == T_IDLE);
        gen_cmd.draw   = 1'b0;
        div_start      = 1'b0;
        div_dividend   = gen_value;
        unique case (state_reg)
            T_CLASS:
            begin
                if (bound_pow2)
                begin
                    gen_cmd.draw = 1'b1;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = '1;
                end
            end
            T_THR:
            begin
                gen_cmd.draw = div_idle;
            end
            T_GDRAW:
            begin
                if (gen_idle)
                begin
                    if (gen_value >= thr_reg)
                    begin
                        gen_cmd.draw = 1'b1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Request sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= T_CLASS;
                    end
                end
                T_CLASS:
                begin
                    state_reg <= bound_pow2 ? T_PDRAW : T_THR;
                end
                T_THR:
                begin
                    if (div_idle)
                    begin
                        state_reg <= T_GDRAW;
                    end
                end
                T_PDRAW:
                begin
                    if (out_load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_GDRAW:
                begin
                    if (div_start)
                    begin
                        state_reg <= T_MOD;
                    end
                end
                T_MOD:
                begin
                    if (out_load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // Request payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            bound_reg <= range_bound;
        end
        if (state_reg == T_THR && div_idle)
        begin
            // Threshold is the all-ones word minus its remainder.
            thr_reg <= ~div_rem;
        end
        if (out_load)
        begin
            result_reg <= out_next;
        end
    end

    clrng_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (gen_cmd),
        .seed  (seed_reg),
        .idle  (gen_idle),
        .value (gen_value)
    );

    clrng_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (bound_reg),
        .idle     (div_idle),
        .rem      (div_rem)
    );

    // A loaded result always lies below a nonzero bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && bound_reg != '0) |=> (random_value < bound_reg))
        else $error("result not below range bound");

    // The generator is only told to draw when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        gen_cmd.draw |-> gen_idle)
        else $error("draw issued to a busy generator");

    // The remainder unit only sees bounds that are neither zero nor a power of two.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (div_idle && bound_reg > 2))
        else $error("remainder unit started with an invalid divisor");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for combined_lcg_xorshift_mwc_rng_core: random bound requests,
// seed writes over the configuration port, results compared against a local generator model.
// Depends on clrng_pkg and the design files of the generator core.
`timescale 1ns / 1ps

module testbench;

    typedef logic [clrng_pkg::WORD_W-1:0] word_t;

    localparam word_t ALL_ONES      = '1;
    localparam word_t LOW_HALF      = 64'h0000_0000_FFFF_FFFF;
    localparam word_t TOP_BIT       = 64'h8000_0000_0000_0000;
    localparam int    PHASES        = 8;
    localparam int    PHASE_ITEMS   = 188;
    localparam int    MAX_GAP       = 18;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    HOLD_SPACING  = 700;
    localparam int    DRAIN_CYCLES  = 200;
    localparam int    CYCLE_LIMIT   = 3000000;
    localparam int    MAX_REPORTS   = 10;

    // Clock, reset and block ports, all at known values from time zero.
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    word_t                         range_bound  = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    word_t                         random_value;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [clrng_pkg::ADDR_W-1:0]  paddr        = '0;
    word_t                         pwdata       = '0;
    word_t                         prdata;
    logic                          pready;

    // Model of the three generator words and the seed register.
    word_t m_lcg;
    word_t m_xsh;
    word_t m_mwc;
    word_t m_seed;

    // Pending requests, and the draws the block owes us in order.
    word_t bound_queue[$];
    word_t owed_draws[$];

    int unsigned req_transfers    = 0;
    int unsigned result_transfers = 0;
    int unsigned error_count      = 0;
    int unsigned cycle_count      = 0;
    logic        out_hold         = 1'b0;

    combined_lcg_xorshift_mwc_rng_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .range_bound  (range_bound),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // One step of all three words, returning the mixed 64-bit value.
    function word_t next_mix();
        word_t mixv;
        m_lcg = m_lcg * clrng_pkg::LCG_MUL + clrng_pkg::LCG_ADD;
        m_xsh = m_xsh ^ (m_xsh >> 17);
        m_xsh = m_xsh ^ (m_xsh << 31);
        m_xsh = m_xsh ^ (m_xsh >> 8);
        m_mwc = word_t'(clrng_pkg::MWC_MUL) * (m_mwc & LOW_HALF) + (m_mwc >> 32);
        mixv  = m_lcg ^ (m_lcg << 21);
        mixv  = mixv ^ (mixv >> 35);
        mixv  = mixv ^ (mixv << 4);
        return (mixv + m_xsh) ^ m_mwc;
    endfunction

    // Reseeding loads fixed words and runs three warm-up steps, copying words in between.
    function void reseed_words(word_t s);
        m_seed = s;
        m_xsh  = clrng_pkg::XS_INIT;
        m_mwc  = word_t'(1);
        m_lcg  = s ^ m_xsh;
        void'(next_mix());
        m_xsh = m_lcg;
        void'(next_mix());
        m_mwc = m_xsh;
        void'(next_mix());
    endfunction

    // Expected draw for one request: masked for zero or a power of two,
    // otherwise rejection sampling followed by a remainder.
    function word_t predict_draw(word_t bound);
        word_t limit;
        word_t r;
        if ((bound & (bound - word_t'(1))) == '0)
            return next_mix() & (bound - word_t'(1));
        limit = ALL_ONES - (ALL_ONES % bound);
        r = next_mix();
        while (r >= limit)
            r = next_mix();
        return r % bound;
    endfunction

    // A random bound, weighted toward the interesting regions of the range.
    function word_t pick_bound();
        word_t b;
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = word_t'(1) << $urandom_range(0, 63);
            2, 3: b = word_t'($urandom_range(2, 1000));
            4: b = {32'd0, $urandom};
            5: b = TOP_BIT + word_t'($urandom_range(1, 1000));
            6: b = ALL_ONES - word_t'($urandom_range(0, 1000));
            7: b = (word_t'(1) << $urandom_range(1, 62)) + word_t'($urandom_range(1, 255));
            default: b = {$urandom, $urandom};
        endcase
        return b;
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Seed write followed by a read-back, both on the configuration port.
    task automatic program_seed(word_t value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = clrng_pkg::ADDR_SEED;
        pwdata  = value;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        reseed_words(value);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== m_seed)
            log_error($sformatf("seed read-back expected %h got %h", m_seed, prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Block until every queued request has gone and every owed draw has come back.
    task automatic wait_idle();
        while (bound_queue.size() != 0 || in_valid || owed_draws.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Request side monitor: every transfer is predicted at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            owed_draws.push_back(predict_draw(range_bound));
            req_transfers++;
        end
    end

    // Result side monitor: compare against the oldest owed draw.
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_transfers++;
            if (owed_draws.size() == 0)
                log_error($sformatf("unexpected result %h", random_value));
            else
            begin
                want = owed_draws.pop_front();
                if (random_value !== want)
                    log_error($sformatf("random_value expected %h got %h", want, random_value));
            end
        end
    end

    // Request driver: presents queued bounds with a random gap after each transfer.
    always @(negedge clk)
    begin
        static int unsigned seen_reqs = 0;
        static int          gap_left  = 0;
        static bit          send_idle = 1'b1;
        bit                 just_taken;
        just_taken = (req_transfers != seen_reqs);
        if (just_taken)
        begin
            seen_reqs = req_transfers;
            gap_left  = send_idle ? $urandom_range(0, MAX_GAP) : 0;
            if ($urandom_range(0, 49) == 0)
                send_idle = !send_idle;
        end
        if (in_valid && !just_taken)
            ;
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (bound_queue.size() > 0)
        begin
            range_bound <= bound_queue.pop_front();
            in_valid    <= 1'b1;
        end
        else
            in_valid <= 1'b0;
    end

    // Result receiver: random stall before each result, plus the long holds below.
    always @(negedge clk)
    begin
        static int unsigned seen_results = 0;
        static int          stall_left   = 0;
        static bit          recv_idle    = 1'b1;
        if (result_transfers != seen_results)
        begin
            seen_results = result_transfers;
            stall_left   = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if ($urandom_range(0, 49) == 0)
                recv_idle = !recv_idle;
        end
        if (out_hold)
            out_stall <= 1'b1;
        else if (out_valid && stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!out_valid && recv_idle)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    // Long receiver hold-offs while the sender keeps offering, so the input backs up.
    always @(negedge clk)
    begin
        static int          hold_left    = 0;
        static int unsigned next_hold_at = 60;
        if (hold_left > 0)
        begin
            hold_left--;
            out_hold <= (hold_left != 0);
        end
        else if (result_transfers >= next_hold_at)
        begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
            out_hold     <= 1'b1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Stimulus: reset, directed bounds under the reset seed, then phases of random
    // bounds, each after a fresh seed but the first.
    initial
    begin
        static word_t directed[] = '{
            '0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd10,
            TOP_BIT, TOP_BIT + 64'd1, ALL_ONES, ALL_ONES - 64'd1,
            64'h1_0000_0000, 64'h1_0000_0001, 64'hFFFF_FFFF,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000,
            '0, 64'd1, 64'd1000003
        };
        word_t seeds[PHASES];
        seeds[0] = '0;
        seeds[1] = ALL_ONES;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = '0;
        seeds[4] = 64'd1;
        seeds[5] = TOP_BIT;
        seeds[6] = {$urandom, $urandom};
        seeds[7] = seeds[6];

        reseed_words('0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            bound_queue.push_back(directed[i]);
        for (int p = 0; p < PHASES; p++)
        begin
            // Phase zero runs on the state left by reset.
            if (p != 0)
                program_seed(seeds[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                bound_queue.push_back(pick_bound());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_draws.size() != 0)
            log_error($sformatf("%0d results never arrived", owed_draws.size()));
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
